>>> hw/rtl/rsa_pkg.sv
// Shared types and constants for the rotated image source address block.
// Holds the register map, the configuration struct and the pipeline enables.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rsa_pkg;

    // Fixed field widths
    localparam int TGT_W      = 12;   // target_x / target_y
    localparam int SRC_W      = 16;   // source_x / source_y
    localparam int ADDR_W     = 24;   // source_address
    localparam int DX_W       = TGT_W + 3;        // target minus 14 bit pivot
    localparam int ANG_W      = 16;               // cosine / sine word
    localparam int PROD_W     = DX_W + ANG_W;     // dx * cos and friends
    localparam int N_STAGES   = 5;

    // Configuration port
    localparam int REG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [REG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_PIVOT_X      = 3'd2,
        REG_PIVOT_Y      = 3'd3,
        REG_COS_OFFSET   = 3'd4,
        REG_SIN_OFFSET   = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic        [12:0] image_width;
        logic        [12:0] image_height;
        logic signed [13:0] pivot_x;
        logic signed [13:0] pivot_y;
        logic signed [15:0] cos_offset;
        logic signed [15:0] sin_offset;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        image_width:  13'd640,
        image_height: 13'd480,
        pivot_x:      14'sd320,
        pivot_y:      14'sd240,
        cos_offset:   16'sd16384,
        sin_offset:   16'sd0
    };

    // Load enables for the rotation datapath stages
    typedef struct packed {
        logic dxy_en;
        logic prod_en;
        logic sum_en;
    } rot_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/rsa_rotate.sv
// Rotation datapath: pivot offset, four products and the two fixed point sums.
// Three register stages; loads are driven by the top level's pipeline control.
// Depends on rsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsa_rotate #(
    parameter int ANGLE_FRAC_BITS = 14,
    parameter int SUM_W = 34
) (
    input  wire logic                            aclk,
    input  wire rsa_pkg::rot_ctrl_t              ctrl,
    input  wire rsa_pkg::cfg_t                   cfg,
    input  wire logic [rsa_pkg::TGT_W-1:0]       target_x,
    input  wire logic [rsa_pkg::TGT_W-1:0]       target_y,
    output logic signed [SUM_W-1:0]              sum_x,
    output logic signed [SUM_W-1:0]              sum_y
);
    import rsa_pkg::*;

    logic signed [DX_W-1:0]   dx_reg, dy_reg, dx_next, dy_next;
    logic signed [PROD_W-1:0] dxc_reg, dys_reg, dyc_reg, dxs_reg;
    logic signed [PROD_W-1:0] dxc_next, dys_next, dyc_next, dxs_next;
    logic signed [SUM_W-1:0]  sx_reg, sy_reg, sx_next, sy_next;

    // Stage 1: offset from the pivot
    always_comb begin
        dx_next = $signed({3'b000, target_x}) - DX_W'(cfg.pivot_x);
        dy_next = $signed({3'b000, target_y}) - DX_W'(cfg.pivot_y);
    end

    // Stage 2: products, one multiplier each
    always_comb begin
        dxc_next = PROD_W'(dx_reg * cfg.cos_offset);
        dys_next = PROD_W'(dy_reg * cfg.sin_offset);
        dyc_next = PROD_W'(dy_reg * cfg.cos_offset);
        dxs_next = PROD_W'(dx_reg * cfg.sin_offset);
    end

    // Stage 3: pivot term plus rotated offset, still scaled by 2^F
    always_comb begin
        sx_next = (SUM_W'(cfg.pivot_x) <<< ANGLE_FRAC_BITS)
                + SUM_W'(dxc_reg) + SUM_W'(dys_reg);
        sy_next = (SUM_W'(cfg.pivot_y) <<< ANGLE_FRAC_BITS)
                + SUM_W'(dyc_reg) - SUM_W'(dxs_reg);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.dxy_en) begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (ctrl.prod_en) begin
            dxc_reg <= dxc_next;
            dys_reg <= dys_next;
            dyc_reg <= dyc_next;
            dxs_reg <= dxs_next;
        end
        if (ctrl.sum_en) begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
        end
    end

    assign sum_x = sx_reg;
    assign sum_y = sy_reg;

endmodule

`default_nettype wire

>>> hw/rtl/rotated_image_source_address.sv
// Top level of the rotated image source address generator.
// Holds the configuration registers, pipeline control, truncation, bounds
// check and address stage. Depends on rsa_pkg and rsa_rotate.
//
// Usage:
//   Input beats on s_valid/s_ready carry one target pixel (s_target_x,
//   s_target_y). Each beat yields exactly one output beat on m_valid/m_ready
//   with the rotated source coordinate, an in-bounds flag and the linear
//   source address (zero when out of bounds; show the pixel as zero then).
//   Configuration: pulse cfg_wr_en with cfg_index/cfg_wdata; write only while
//   the pipeline is empty. Unknown indexes are dropped.
//   Pipeline: five register stages (offset, multiply, sum, truncate/bounds,
//   address). A beat accepted on the s_ port is loaded into the offset
//   register and passes through the others in that order to the m_ port.
//   Throughput: one beat per clock while m_ready is high; every stage holds
//   one beat and valid bits travel with the data.
//   Stall: when m_ready is low the stages fill up behind the output register;
//   each stage advances whenever it is empty or the stage after it advances,
//   so bubbles collapse and s_ready drops only when all five stages are full.
//   Reset (aresetn low, synchronous): all valid bits clear, registers return
//   to 640 x 480, pivot (320, 240), cos 1.0, sin 0.
`timescale 1ns / 1ps
`default_nettype none

module rotated_image_source_address #(
    parameter int MAX_DIM         = 4096,
    parameter int ANGLE_FRAC_BITS = 14
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration write port
    input  wire logic                                cfg_wr_en,
    input  wire logic [rsa_pkg::REG_INDEX_W-1:0]     cfg_index,
    input  wire logic [rsa_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // target pixel beats
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [rsa_pkg::TGT_W-1:0]           s_target_x,
    input  wire logic [rsa_pkg::TGT_W-1:0]           s_target_y,
    // source address beats
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [rsa_pkg::SRC_W-1:0]         m_source_x,
    output logic signed [rsa_pkg::SRC_W-1:0]         m_source_y,
    output logic                                     m_in_bounds,
    output logic [rsa_pkg::ADDR_W-1:0]               m_source_address
);
    import rsa_pkg::*;

    // Sum width: pivot * 2^F or a product, whichever is wider, plus two
    // bits of growth for the three-term sum.
    localparam int TERM_W = (14 + ANGLE_FRAC_BITS > PROD_W) ?
                            14 + ANGLE_FRAC_BITS : PROD_W;
    localparam int SUM_W  = TERM_W + 2;
    localparam int Q_W    = SUM_W - ANGLE_FRAC_BITS;
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int CMP_W  = (Q_W > DIM_W + 1) ? Q_W : DIM_W + 1;
    localparam int LIN_W  = 2 * DIM_W + 1;
    localparam logic signed [Q_W-1:0] SAT_HI = Q_W'(32767);
    localparam logic signed [Q_W-1:0] SAT_LO = Q_W'(-32768);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  cfg_next.image_width  = cfg_wdata[12:0];
                REG_IMAGE_HEIGHT: cfg_next.image_height = cfg_wdata[12:0];
                REG_PIVOT_X:      cfg_next.pivot_x      = $signed(cfg_wdata[13:0]);
                REG_PIVOT_Y:      cfg_next.pivot_y      = $signed(cfg_wdata[13:0]);
                REG_COS_OFFSET:   cfg_next.cos_offset   = $signed(cfg_wdata);
                REG_SIN_OFFSET:   cfg_next.sin_offset   = $signed(cfg_wdata);
                default:          cfg_next = cfg_reg;   // drop unknown index
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Effective image size, clamped to MAX_DIM
    logic [DIM_W-1:0] eff_w, eff_h;

    always_comb begin
        if (32'(cfg_reg.image_width) > 32'(MAX_DIM)) begin
            eff_w = DIM_W'(MAX_DIM);
        end else begin
            eff_w = DIM_W'(cfg_reg.image_width);
        end
        if (32'(cfg_reg.image_height) > 32'(MAX_DIM)) begin
            eff_h = DIM_W'(MAX_DIM);
        end else begin
            eff_h = DIM_W'(cfg_reg.image_height);
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: a stage advances when empty or when the next one
    // advances. Stage N_STAGES-1 is the output register.
    // ------------------------------------------------------------------
    logic [N_STAGES-1:0] valid_reg, valid_next, adv;

    always_comb begin
        adv[N_STAGES-1] = !valid_reg[N_STAGES-1] || m_ready;
        for (int i = N_STAGES - 2; i >= 0; i--) begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (adv[0]) begin
            valid_next[0] = s_valid;
        end
        for (int i = 1; i < N_STAGES; i++) begin
            if (adv[i]) begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = adv[0];
    assign m_valid = valid_reg[N_STAGES-1];

    // ------------------------------------------------------------------
    // Stages 1-3: offset, multiply, sum
    // ------------------------------------------------------------------
    rot_ctrl_t               rot_ctrl;
    logic signed [SUM_W-1:0] sum_x, sum_y;

    assign rot_ctrl.dxy_en  = adv[0];
    assign rot_ctrl.prod_en = adv[1];
    assign rot_ctrl.sum_en  = adv[2];

    rsa_rotate #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .SUM_W           (SUM_W)
    ) u_rotate (
        .aclk     (aclk),
        .ctrl     (rot_ctrl),
        .cfg      (cfg_reg),
        .target_x (s_target_x),
        .target_y (s_target_y),
        .sum_x    (sum_x),
        .sum_y    (sum_y)
    );

    // ------------------------------------------------------------------
    // Stage 4: truncate toward zero, saturate, bounds check
    // ------------------------------------------------------------------
    logic signed [Q_W-1:0]   qx, qy;
    logic                    rnd_x, rnd_y;
    logic signed [CMP_W-1:0] qx_ext, qy_ext, w_ext, h_ext;
    logic signed [SRC_W-1:0] sx4_reg, sy4_reg, sx4_next, sy4_next;
    logic [DIM_W-1:0]        ax4_reg, ay4_reg;
    logic                    in4_reg, in4_next;

    always_comb begin
        // arithmetic shift floors; bump negative values with a remainder
        rnd_x = sum_x[SUM_W-1] && (|sum_x[ANGLE_FRAC_BITS-1:0]);
        rnd_y = sum_y[SUM_W-1] && (|sum_y[ANGLE_FRAC_BITS-1:0]);
        qx = Q_W'(sum_x >>> ANGLE_FRAC_BITS) + $signed({{(Q_W-1){1'b0}}, rnd_x});
        qy = Q_W'(sum_y >>> ANGLE_FRAC_BITS) + $signed({{(Q_W-1){1'b0}}, rnd_y});

        qx_ext = CMP_W'(qx);
        qy_ext = CMP_W'(qy);
        w_ext  = $signed(CMP_W'(eff_w));
        h_ext  = $signed(CMP_W'(eff_h));
        in4_next = !qx[Q_W-1] && !qy[Q_W-1] && (qx_ext < w_ext) && (qy_ext < h_ext);

        if (qx > SAT_HI) begin
            sx4_next = SRC_W'(SAT_HI);
        end else if (qx < SAT_LO) begin
            sx4_next = SRC_W'(SAT_LO);
        end else begin
            sx4_next = SRC_W'(qx);
        end
        if (qy > SAT_HI) begin
            sy4_next = SRC_W'(SAT_HI);
        end else if (qy < SAT_LO) begin
            sy4_next = SRC_W'(SAT_LO);
        end else begin
            sy4_next = SRC_W'(qy);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            sx4_reg <= sx4_next;
            sy4_reg <= sy4_next;
            in4_reg <= in4_next;
            ax4_reg <= DIM_W'(qx);   // meaningful only when in bounds
            ay4_reg <= DIM_W'(qy);
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: linear address into the output register
    // ------------------------------------------------------------------
    logic [LIN_W-1:0]        lin;
    logic [ADDR_W-1:0]       addr5_reg, addr5_next;
    logic signed [SRC_W-1:0] sx5_reg, sy5_reg;
    logic                    in5_reg;

    always_comb begin
        lin = LIN_W'(ay4_reg) * LIN_W'(eff_w) + LIN_W'(ax4_reg);
        addr5_next = in4_reg ? ADDR_W'(lin) : '0;
    end

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            sx5_reg   <= sx4_reg;
            sy5_reg   <= sy4_reg;
            in5_reg   <= in4_reg;
            addr5_reg <= addr5_next;
        end
    end

    assign m_source_x       = sx5_reg;
    assign m_source_y       = sy5_reg;
    assign m_in_bounds      = in5_reg;
    assign m_source_address = addr5_reg;

endmodule

`default_nettype wire
